>>> design/rlfa_pkg.sv
// shared types and constants for the requested-or-lowest-free allocator
// used by rlfa_ctrl, rlfa_dp and requested_or_lowest_free_allocator
package rlfa_pkg;

    // field widths of the stream words and the configuration register
    localparam int ADDR_W    = 10;
    localparam int COUNT_W   = 11;
    localparam int STATUS_W  = 2;
    localparam int CFG_W     = 4;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    // largest address space, 2^MAX_ADDR_BITS slots
    localparam int MAX_ADDR_BITS = ADDR_W;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd10;

    // opcodes
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_HELD = 2'd2;

    // node pointer moves
    localparam logic [2:0] MV_HOLD   = 3'd0;
    localparam logic [2:0] MV_LEAF   = 3'd1;
    localparam logic [2:0] MV_ROOT   = 3'd2;
    localparam logic [2:0] MV_CHILD  = 3'd3;
    localparam logic [2:0] MV_PARENT = 3'd4;
    localparam logic [2:0] MV_NEXT   = 3'd5;

    typedef struct packed {
        logic                load;
        logic                clr_step;
        logic [2:0]          move;
        logic                upd;
        logic                upd_first;
        logic                bit_from_data;
        logic                fin;
        logic [STATUS_W-1:0] status;
        logic                grant;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic leaf_used;
        logic pair_full;
        logic at_bottom;
        logic at_top;
        logic clr_last;
        logic op_release;
        logic out_free;
    } dp_stat_t;

endpackage

>>> design/rlfa_ctrl.sv
// controller state machine of the allocator: clearing pass, lookup, walk, path update
// depends on rlfa_pkg for the command and status structs
module rlfa_ctrl
    import rlfa_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t st,
    output dp_cmd_t  cmd
);

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_ROOT  = 3'd3;
    localparam logic [2:0] S_WALK  = 3'd4;
    localparam logic [2:0] S_UPD   = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        cmd.move   = MV_HOLD;
        s_tready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLR: begin
                cmd.clr_step = 1'b1;
                if (st.clr_last) begin
                    state_next = S_IDLE;
                end else begin
                    cmd.move = MV_NEXT;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    cmd.move   = MV_LEAF;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (st.op_release && !st.leaf_used) begin
                    cmd.fin    = 1'b1;
                    cmd.status = ST_NOT_HELD;
                    state_next = S_FIN;
                end else if (!st.op_release && st.leaf_used) begin
                    cmd.move   = MV_ROOT;
                    state_next = S_ROOT;
                end else begin
                    cmd.upd       = 1'b1;
                    cmd.upd_first = 1'b1;
                end
            end
            S_ROOT, S_WALK: begin
                if (state_reg == S_ROOT && st.pair_full) begin
                    cmd.fin    = 1'b1;
                    cmd.status = ST_FULL;
                    state_next = S_FIN;
                end else if (st.at_bottom) begin
                    cmd.upd           = 1'b1;
                    cmd.upd_first     = 1'b1;
                    cmd.bit_from_data = 1'b1;
                end else begin
                    cmd.move   = MV_CHILD;
                    state_next = S_WALK;
                end
            end
            S_UPD: begin
                cmd.upd = 1'b1;
            end
            S_FIN: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLR;
            end
        endcase

        // one tree level per cycle, finishing once the top pair is written
        if (cmd.upd) begin
            if (st.at_top) begin
                cmd.fin     = 1'b1;
                cmd.status  = ST_OK;
                cmd.grant   = !st.op_release;
                cmd.cnt_inc = !st.op_release;
                cmd.cnt_dec = st.op_release;
                state_next  = S_FIN;
            end else begin
                cmd.move   = MV_PARENT;
                state_next = S_UPD;
            end
        end
    end

    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word accepted while one is in flight");

    a_upd_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.upd && !cmd.upd_first) |-> $past(cmd.upd))
        else $error("path update resumed after a gap");

    a_fin_once: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fin |=> !cmd.fin)
        else $error("two completions for one word");

endmodule

>>> design/rlfa_dp.sv
// datapath of the allocator: pair memory of full marks, node pointer, count, output register
// depends on rlfa_pkg; driven by rlfa_ctrl
module rlfa_dp
    import rlfa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dp_cmd_t               cmd,
    output dp_stat_t              st,
    input  logic                  cfg_we,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic [STATUS_W-1:0]   m_tuser
);

    localparam int AW     = MAX_ADDR_BITS;
    localparam int CW     = MAX_ADDR_BITS + 1;
    localparam int KW     = $clog2(MAX_ADDR_BITS + 1);
    localparam int LEAVES = 1 << MAX_ADDR_BITS;
    localparam int INNER  = LEAVES - 1;
    localparam int PAD_W  = M_TDATA_W - COUNT_W - ADDR_W;
    localparam logic [AW-1:0] BOTTOM   = AW'((LEAVES / 2) - 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(INNER - 1);

    // entry n holds the full marks of the two children of heap node n
    logic [1:0] pair_mem [0:INNER-1];
    logic [1:0] rd_data_reg;

    logic [CFG_W-1:0]    cfg_reg;
    logic [AW-1:0]       pidx_reg, pidx_next;
    logic                cbit_reg, cbit_next;
    logic                full_reg;
    logic                set_reg;
    logic                op_reg;
    logic [AW-1:0]       slot_reg;
    logic [CW-1:0]       count_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [ADDR_W-1:0]   granted_reg;
    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [STATUS_W-1:0] m_tuser_reg;

    logic [KW-1:0] k_act;
    logic [AW:0]   span;
    logic [AW-1:0] addr_mask, req_slot, leaf_par, root_idx, child_idx, parent_idx, leaf_slot;
    logic          eff_bit, new_val;
    logic [1:0]    new_pair, wr_data;
    logic          wr_en;

    always_comb begin
        if (cfg_reg == '0) begin
            k_act = KW'(1);
        end else if (int'(cfg_reg) > MAX_ADDR_BITS) begin
            k_act = KW'(MAX_ADDR_BITS);
        end else begin
            k_act = KW'(cfg_reg);
        end
    end

    assign span       = (AW+1)'(1) << k_act;
    assign addr_mask  = AW'(span - (AW+1)'(1));
    assign req_slot   = AW'(s_tdata[ADDR_W-1:0]) & addr_mask;
    assign leaf_par   = (req_slot >> 1) + BOTTOM;
    assign root_idx   = (AW'(1) << (AW - int'(k_act))) - AW'(1);
    assign child_idx  = AW'({pidx_reg, 1'b0}) + AW'(1) + AW'(rd_data_reg[0]);
    assign parent_idx = (pidx_reg - AW'(1)) >> 1;
    assign leaf_slot  = AW'({pidx_reg - BOTTOM, rd_data_reg[0]});

    assign eff_bit = cmd.bit_from_data ? rd_data_reg[0] : cbit_reg;
    assign new_val = cmd.upd_first ? set_reg : (set_reg & full_reg);

    always_comb begin
        new_pair          = rd_data_reg;
        new_pair[eff_bit] = new_val;
    end

    assign wr_en   = cmd.upd | cmd.clr_step;
    assign wr_data = cmd.clr_step ? 2'b00 : new_pair;

    always_comb begin
        pidx_next = pidx_reg;
        cbit_next = cbit_reg;
        case (cmd.move)
            MV_LEAF: begin
                pidx_next = leaf_par;
                cbit_next = req_slot[0];
            end
            MV_ROOT:   pidx_next = root_idx;
            MV_CHILD:  pidx_next = child_idx;
            MV_PARENT: begin
                pidx_next = parent_idx;
                cbit_next = ~pidx_reg[0];
            end
            MV_NEXT:   pidx_next = pidx_reg + AW'(1);
            default:   pidx_next = pidx_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pair_mem[pidx_reg] <= wr_data;
        end
        rd_data_reg <= pair_mem[pidx_next];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg      <= CFG_RESET;
            pidx_reg     <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                cfg_reg <= cfg_wdata;
            end
            pidx_reg <= pidx_next;
            if (cmd.fin && cmd.cnt_inc) begin
                count_reg <= count_reg + CW'(1);
            end else if (cmd.fin && cmd.cnt_dec) begin
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cbit_reg <= cbit_next;
        if (cmd.upd) begin
            full_reg <= &new_pair;
        end
        if (cmd.load) begin
            op_reg   <= s_tuser;
            set_reg  <= (s_tuser == OP_ALLOC);
            slot_reg <= req_slot;
        end else if (cmd.bit_from_data) begin
            slot_reg <= leaf_slot;
        end
        if (cmd.fin) begin
            status_reg  <= cmd.status;
            granted_reg <= cmd.grant ? ADDR_W'(slot_reg) : '0;
        end
        if (cmd.out_load) begin
            m_tdata_reg <= {{PAD_W{1'b0}}, COUNT_W'(count_reg), granted_reg};
            m_tuser_reg <= status_reg;
        end
    end

    assign st.leaf_used  = rd_data_reg[cbit_reg];
    assign st.pair_full  = &rd_data_reg;
    assign st.at_bottom  = (pidx_reg >= BOTTOM);
    assign st.at_top     = (pidx_reg == '0);
    assign st.clr_last   = (pidx_reg == LAST_IDX);
    assign st.op_release = (op_reg == OP_RELEASE);
    assign st.out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(LEAVES))
        else $error("allocated count beyond address space");

    a_count_only_on_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.fin |=> $stable(count_reg))
        else $error("allocated count moved outside completion");

    a_fail_no_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_OK) |-> (m_tdata[ADDR_W-1:0] == '0))
        else $error("failed word carries a granted address");

endmodule

>>> design/requested_or_lowest_free_allocator.sv
// requested-or-lowest-free address allocator top level: rlfa_ctrl plus rlfa_dp, uses rlfa_pkg
// a release of a free address ends at the lookup, a full address space at the root check, a
//   granted request or release after the path update, and a request whose slot is taken after a
//   walk and update; next word taken the cycle after the result is registered (one word in flight)
// the walk and path update go one tree level per cycle, one read and one write of the pair memory
// reset: synchronous active-low; a clearing pass wipes all the full marks before use
module requested_or_lowest_free_allocator
    import rlfa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration: active address bits
    input  logic                  cfg_we,
    input  logic [CFG_W-1:0]      cfg_wdata,
    // request words
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [9:0] address, rest zero
    input  logic                  s_tuser,   // [0] opcode
    // result words
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [9:0] granted_address, [20:10] used_count
    output logic [STATUS_W-1:0]   m_tuser    // [1:0] status
);

    // command and status between the sequencer and the datapath
    dp_cmd_t  cmd;
    dp_stat_t st;

    // sequencer: clearing pass, lookup of the requested slot, walk, path update
    rlfa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // datapath: full-mark memory, node pointer, used count and the result register
    rlfa_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .st        (st),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
